### rtl/core/ptts_pkg.sv
package ptts_pkg;

    localparam int NUM_SLOTS   = 8;
    localparam int SLOT_BITS   = 3;
    localparam int PERIOD_BITS = 16;
    localparam int TIME_BITS   = 32;
    localparam int KIND_BITS   = 3;

    localparam int IN_DATA_BITS  = 56;
    localparam int OUT_DATA_BITS = 40;

    localparam logic [KIND_BITS-1:0] KIND_TICK    = 3'd0;
    localparam logic [KIND_BITS-1:0] KIND_ADD     = 3'd1;
    localparam logic [KIND_BITS-1:0] KIND_REMOVE  = 3'd2;
    localparam logic [KIND_BITS-1:0] KIND_SERVICE = 3'd3;
    localparam logic [KIND_BITS-1:0] KIND_SET     = 3'd4;

    localparam logic [2:0] BANK_NONE   = 3'd0;
    localparam logic [2:0] BANK_ADD    = 3'd1;
    localparam logic [2:0] BANK_REMOVE = 3'd2;
    localparam logic [2:0] BANK_TICK   = 3'd3;
    localparam logic [2:0] BANK_SERVE  = 3'd4;

    typedef struct packed {
        logic [2:0]             op;
        logic [SLOT_BITS-1:0]   idx;
        logic [PERIOD_BITS-1:0] period;
    } bank_cmd_t;

    typedef struct packed {
        logic active;
        logic pending;
        logic period_zero;
    } bank_rd_t;

endpackage

### rtl/core/ptts_countdown_unit.sv
module ptts_countdown_unit (
    input  logic [ptts_pkg::PERIOD_BITS-1:0] count,
    input  logic [ptts_pkg::PERIOD_BITS-1:0] period,
    output logic [ptts_pkg::PERIOD_BITS-1:0] count_next,
    output logic                             fire
);

    assign fire       = (count == '0);
    assign count_next = fire ? period : count - ptts_pkg::PERIOD_BITS'(1);

endmodule

### rtl/core/ptts_slot_bank.sv
module ptts_slot_bank (
    input  logic                clk,
    input  logic                rst_n,
    input  ptts_pkg::bank_cmd_t cmd,
    output ptts_pkg::bank_rd_t  rd
);

    logic [ptts_pkg::NUM_SLOTS-1:0]   active_reg;
    logic [ptts_pkg::NUM_SLOTS-1:0]   pending_reg;
    logic [ptts_pkg::PERIOD_BITS-1:0] period_mem [ptts_pkg::NUM_SLOTS];
    logic [ptts_pkg::PERIOD_BITS-1:0] count_mem  [ptts_pkg::NUM_SLOTS];
    logic [ptts_pkg::PERIOD_BITS-1:0] count_next;
    logic                             fire;

    ptts_countdown_unit u_countdown (
        .count      (count_mem[cmd.idx]),
        .period     (period_mem[cmd.idx]),
        .count_next (count_next),
        .fire       (fire)
    );

    assign rd.active      = active_reg[cmd.idx];
    assign rd.pending     = pending_reg[cmd.idx];
    assign rd.period_zero = (period_mem[cmd.idx] == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= '0;
            pending_reg <= '0;
        end
        else
        begin
            case (cmd.op)
                ptts_pkg::BANK_ADD:
                begin
                    active_reg[cmd.idx]  <= 1'b1;
                    pending_reg[cmd.idx] <= 1'b0;
                end
                ptts_pkg::BANK_REMOVE:
                begin
                    active_reg[cmd.idx]  <= 1'b0;
                    pending_reg[cmd.idx] <= 1'b0;
                end
                ptts_pkg::BANK_TICK:
                begin
                    if (active_reg[cmd.idx] && fire)
                    begin
                        pending_reg[cmd.idx] <= 1'b1;
                    end
                end
                ptts_pkg::BANK_SERVE:
                begin
                    pending_reg[cmd.idx] <= 1'b0;
                    if (period_mem[cmd.idx] == '0)
                    begin
                        active_reg[cmd.idx] <= 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            ptts_pkg::BANK_ADD:
            begin
                period_mem[cmd.idx] <= cmd.period;
                count_mem[cmd.idx]  <= cmd.period;
            end
            ptts_pkg::BANK_TICK:
            begin
                if (active_reg[cmd.idx])
                begin
                    count_mem[cmd.idx] <= count_next;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

### rtl/core/periodic_task_tick_scheduler.sv
// Software-timer style task scheduler with eight task slots and a free-running
// millisecond counter. Each transaction on the input stream carries one command
// in s_tuser and returns exactly one result transaction with the counter value
// after the command. A tick walks the slots one per cycle through a single
// shared countdown unit and then advances the counter; a service scans the
// slots in the same way from slot zero and finishes at the lowest pending slot.
// Add, remove, set time and unused commands go straight to the result. The
// input is not ready while a command is in progress. A finished result waits
// in the output register, and the next command is accepted while it waits.
module periodic_task_tick_scheduler (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // slot[2:0], period_ms[18:3], time_value[50:19], zero fill above.
    input  logic [ptts_pkg::IN_DATA_BITS-1:0]   s_tdata,
    // kind[2:0].
    input  logic [ptts_pkg::KIND_BITS-1:0]      s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // time_now[31:0], was_duplicate[32], ready_valid[33], ready_slot[36:34],
    // ready_retired[37], zero fill above.
    output logic [ptts_pkg::OUT_DATA_BITS-1:0]  m_tdata
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_TICK = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    localparam logic [ptts_pkg::SLOT_BITS-1:0] LAST_IDX =
        ptts_pkg::SLOT_BITS'(ptts_pkg::NUM_SLOTS - 1);

    logic [1:0]                       state_reg, state_next;
    logic [ptts_pkg::SLOT_BITS-1:0]   idx_reg, idx_next;
    logic [ptts_pkg::TIME_BITS-1:0]   time_reg, time_next;
    logic                             dup_reg, dup_next;
    logic                             rvalid_reg, rvalid_next;
    logic [ptts_pkg::SLOT_BITS-1:0]   rslot_reg, rslot_next;
    logic                             retired_reg, retired_next;
    logic                             m_tvalid_reg, m_tvalid_next;
    logic [ptts_pkg::OUT_DATA_BITS-1:0] m_tdata_reg, m_tdata_next;

    logic [ptts_pkg::SLOT_BITS-1:0]   in_slot;
    logic [ptts_pkg::PERIOD_BITS-1:0] in_period;
    logic [ptts_pkg::TIME_BITS-1:0]   in_time;
    logic                             in_slot_ok;
    logic                             accept;

    ptts_pkg::bank_cmd_t bank_cmd;
    ptts_pkg::bank_rd_t  bank_rd;

    assign in_slot    = s_tdata[ptts_pkg::SLOT_BITS-1:0];
    assign in_period  = s_tdata[ptts_pkg::SLOT_BITS +: ptts_pkg::PERIOD_BITS];
    assign in_time    = s_tdata[ptts_pkg::SLOT_BITS + ptts_pkg::PERIOD_BITS +:
                                ptts_pkg::TIME_BITS];
    assign in_slot_ok = (32'(in_slot) < ptts_pkg::NUM_SLOTS);

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    ptts_slot_bank u_bank (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (bank_cmd),
        .rd    (bank_rd)
    );

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        time_next     = time_reg;
        dup_next      = dup_reg;
        rvalid_next   = rvalid_reg;
        rslot_next    = rslot_reg;
        retired_next  = retired_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;

        bank_cmd.op     = ptts_pkg::BANK_NONE;
        bank_cmd.idx    = (state_reg == ST_IDLE) ? in_slot : idx_reg;
        bank_cmd.period = in_period;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    dup_next     = 1'b0;
                    rvalid_next  = 1'b0;
                    rslot_next   = '0;
                    retired_next = 1'b0;
                    idx_next     = '0;
                    state_next   = ST_DONE;
                    case (s_tuser)
                        ptts_pkg::KIND_TICK:
                        begin
                            state_next = ST_TICK;
                        end
                        ptts_pkg::KIND_ADD:
                        begin
                            if (in_slot_ok)
                            begin
                                bank_cmd.op = ptts_pkg::BANK_ADD;
                                dup_next    = bank_rd.active;
                            end
                        end
                        ptts_pkg::KIND_REMOVE:
                        begin
                            if (in_slot_ok)
                            begin
                                bank_cmd.op = ptts_pkg::BANK_REMOVE;
                            end
                        end
                        ptts_pkg::KIND_SERVICE:
                        begin
                            state_next = ST_SCAN;
                        end
                        ptts_pkg::KIND_SET:
                        begin
                            time_next = in_time;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_TICK:
            begin
                bank_cmd.op = ptts_pkg::BANK_TICK;
                if (idx_reg == LAST_IDX)
                begin
                    time_next  = time_reg + ptts_pkg::TIME_BITS'(1);
                    state_next = ST_DONE;
                end
                else
                begin
                    idx_next = idx_reg + ptts_pkg::SLOT_BITS'(1);
                end
            end
            ST_SCAN:
            begin
                if (bank_rd.active && bank_rd.pending)
                begin
                    bank_cmd.op  = ptts_pkg::BANK_SERVE;
                    rvalid_next  = 1'b1;
                    rslot_next   = idx_reg;
                    retired_next = bank_rd.period_zero;
                    state_next   = ST_DONE;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    idx_next = idx_reg + ptts_pkg::SLOT_BITS'(1);
                end
            end
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {2'b00, retired_reg, rslot_reg, rvalid_reg, dup_reg,
                                     time_reg};
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            idx_reg      <= '0;
            time_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            time_reg     <= time_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dup_reg     <= dup_next;
        rvalid_reg  <= rvalid_next;
        rslot_reg   <= rslot_next;
        retired_reg <= retired_next;
        m_tdata_reg <= m_tdata_next;
    end

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TICK && idx_reg == LAST_IDX)
        |=> (time_reg == $past(time_reg) + ptts_pkg::TIME_BITS'(1)))
        else $error("Tick walk did not advance the time counter.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (s_tuser == ptts_pkg::KIND_TICK || s_tuser == ptts_pkg::KIND_SERVICE))
        |=> ((state_reg == ST_TICK || state_reg == ST_SCAN) && idx_reg == '0))
        else $error("Slot walk did not start at slot zero.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && bank_rd.active && bank_rd.pending)
        |=> (state_reg == ST_DONE && rvalid_reg && rslot_reg == $past(idx_reg)))
        else $error("Service scan passed a pending slot.");
`endif

endmodule

### tb/sv/scheduler_checker.sv
module scheduler_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    // slot[2:0], period_ms[18:3], time_value[50:19], zero fill above.
    input  logic [ptts_pkg::IN_DATA_BITS-1:0]   s_tdata,
    // kind[2:0].
    input  logic [ptts_pkg::KIND_BITS-1:0]      s_tuser,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    // time_now[31:0], was_duplicate[32], ready_valid[33], ready_slot[36:34],
    // ready_retired[37], zero fill above.
    input  logic [ptts_pkg::OUT_DATA_BITS-1:0]  m_tdata,
    output int                                  fail_count,
    output int                                  replies_owed,
    output int                                  replies_checked
);

    typedef struct packed {
        logic                           ready_retired;
        logic [ptts_pkg::SLOT_BITS-1:0] ready_slot;
        logic                           ready_valid;
        logic                           was_duplicate;
        logic [ptts_pkg::TIME_BITS-1:0] time_now;
    } sched_reply_t;

    logic [ptts_pkg::NUM_SLOTS-1:0]   slot_live;
    logic [ptts_pkg::NUM_SLOTS-1:0]   slot_due;
    logic [ptts_pkg::PERIOD_BITS-1:0] slot_reload [ptts_pkg::NUM_SLOTS];
    logic [ptts_pkg::PERIOD_BITS-1:0] slot_count [ptts_pkg::NUM_SLOTS];
    logic [ptts_pkg::TIME_BITS-1:0]   now_ms;
    sched_reply_t                     reply_queue [$];

    function automatic sched_reply_t apply_command(
        input logic [ptts_pkg::KIND_BITS-1:0]   kind,
        input logic [ptts_pkg::SLOT_BITS-1:0]   idx,
        input logic [ptts_pkg::PERIOD_BITS-1:0] per,
        input logic [ptts_pkg::TIME_BITS-1:0]   tval
    );
        sched_reply_t r;
        bit           found;
        r = '0;
        found = 1'b0;
        case (kind)
            ptts_pkg::KIND_TICK:
            begin
                for (int i = 0; i < ptts_pkg::NUM_SLOTS; i++)
                begin
                    if (slot_live[i])
                    begin
                        if (slot_count[i] == '0)
                        begin
                            slot_due[i] = 1'b1;
                            slot_count[i] = slot_reload[i];
                        end
                        else
                        begin
                            slot_count[i] = slot_count[i] - 1'b1;
                        end
                    end
                end
                now_ms = now_ms + 1'b1;
            end
            ptts_pkg::KIND_ADD:
            begin
                r.was_duplicate = slot_live[idx];
                slot_live[idx] = 1'b1;
                slot_due[idx] = 1'b0;
                slot_reload[idx] = per;
                slot_count[idx] = per;
            end
            ptts_pkg::KIND_REMOVE:
            begin
                slot_live[idx] = 1'b0;
                slot_due[idx] = 1'b0;
            end
            ptts_pkg::KIND_SERVICE:
            begin
                for (int i = 0; i < ptts_pkg::NUM_SLOTS; i++)
                begin
                    if (!found && slot_live[i] && slot_due[i])
                    begin
                        found = 1'b1;
                        slot_due[i] = 1'b0;
                        r.ready_valid = 1'b1;
                        r.ready_slot = ptts_pkg::SLOT_BITS'(i);
                        if (slot_reload[i] == '0)
                        begin
                            slot_live[i] = 1'b0;
                            r.ready_retired = 1'b1;
                        end
                    end
                end
            end
            ptts_pkg::KIND_SET:
            begin
                now_ms = tval;
            end
            default:
            begin
            end
        endcase
        r.time_now = now_ms;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got_v,
                                   input logic [31:0] want_v);
        if (fail_count < 50)
        begin
            $display("Mismatch on %s at transaction %0d: got %0h, expected %0h",
                     what, replies_checked, got_v, want_v);
        end
        fail_count = fail_count + 1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        sched_reply_t got_reply;
        sched_reply_t want_reply;
        if (!rst_n)
        begin
            slot_live = '0;
            slot_due = '0;
            now_ms = '0;
            reply_queue.delete();
            fail_count = 0;
            replies_owed <= 0;
            replies_checked <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                reply_queue.push_back(apply_command(s_tuser, s_tdata[2:0], s_tdata[18:3],
                                                    s_tdata[50:19]));
            end
            if (m_tvalid && m_tready)
            begin
                got_reply = m_tdata[37:0];
                if (reply_queue.size() == 0)
                begin
                    report_mismatch("result with nothing outstanding, time_now",
                                    got_reply.time_now, '0);
                end
                else
                begin
                    want_reply = reply_queue.pop_front();
                    if (got_reply.time_now !== want_reply.time_now)
                        report_mismatch("time_now", got_reply.time_now,
                                        want_reply.time_now);
                    if (got_reply.was_duplicate !== want_reply.was_duplicate)
                        report_mismatch("was_duplicate", 32'(got_reply.was_duplicate),
                                        32'(want_reply.was_duplicate));
                    if (got_reply.ready_valid !== want_reply.ready_valid)
                        report_mismatch("ready_valid", 32'(got_reply.ready_valid),
                                        32'(want_reply.ready_valid));
                    if (got_reply.ready_slot !== want_reply.ready_slot)
                        report_mismatch("ready_slot", 32'(got_reply.ready_slot),
                                        32'(want_reply.ready_slot));
                    if (got_reply.ready_retired !== want_reply.ready_retired)
                        report_mismatch("ready_retired", 32'(got_reply.ready_retired),
                                        32'(want_reply.ready_retired));
                    replies_checked <= replies_checked + 1;
                end
            end
            replies_owed <= reply_queue.size();
        end
    end

endmodule

### tb/sv/testbench.sv
module testbench;

    localparam logic [ptts_pkg::KIND_BITS-1:0] KIND_SPARE_LO = 3'd5;
    localparam logic [ptts_pkg::KIND_BITS-1:0] KIND_SPARE_HI = 3'd7;
    localparam int PHASE_ITEMS = 342;
    localparam int LONG_HOLD   = 300;
    localparam int CYCLE_LIMIT = 400000;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               s_tvalid = 1'b0;
    logic                               s_tready;
    logic [ptts_pkg::IN_DATA_BITS-1:0]  s_tdata = '0;
    logic [ptts_pkg::KIND_BITS-1:0]     s_tuser = '0;
    logic                               m_tvalid;
    logic                               m_tready = 1'b0;
    logic [ptts_pkg::OUT_DATA_BITS-1:0] m_tdata;

    int fail_count;
    int replies_owed;
    int replies_checked;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_requests = 0;
    int holds_done = 0;
    int hold_left = 0;
    int cycles = 0;
    int kind_seen [8];

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    periodic_task_tick_scheduler u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    scheduler_checker u_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .fail_count      (fail_count),
        .replies_owed    (replies_owed),
        .replies_checked (replies_checked)
    );

    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_requests != holds_done)
        begin
            m_tready <= 1'b0;
            hold_left <= LONG_HOLD;
            holds_done <= holds_done + 1;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycles, replies_owed);
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_command(
        input logic [ptts_pkg::KIND_BITS-1:0]   kind,
        input logic [ptts_pkg::SLOT_BITS-1:0]   idx,
        input logic [ptts_pkg::PERIOD_BITS-1:0] per,
        input logic [ptts_pkg::TIME_BITS-1:0]   tval
    );
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {5'b00000, tval, per, idx};
        do
            @(posedge clk);
        while (!s_tready);
        kind_seen[kind] = kind_seen[kind] + 1;
    endtask

    task automatic send_random();
        int                               pick;
        logic [ptts_pkg::KIND_BITS-1:0]   kind;
        logic [ptts_pkg::PERIOD_BITS-1:0] per;
        logic [ptts_pkg::TIME_BITS-1:0]   tval;
        pick = $urandom_range(99);
        if (pick < 45)
            kind = ptts_pkg::KIND_TICK;
        else if (pick < 62)
            kind = ptts_pkg::KIND_ADD;
        else if (pick < 70)
            kind = ptts_pkg::KIND_REMOVE;
        else if (pick < 92)
            kind = ptts_pkg::KIND_SERVICE;
        else if (pick < 97)
            kind = ptts_pkg::KIND_SET;
        else
            kind = ptts_pkg::KIND_BITS'($urandom_range(KIND_SPARE_HI, KIND_SPARE_LO));
        pick = $urandom_range(99);
        if (pick < 70)
            per = ptts_pkg::PERIOD_BITS'($urandom_range(4, 0));
        else if (pick < 90)
            per = ptts_pkg::PERIOD_BITS'($urandom_range(40, 5));
        else if (pick < 98)
            per = ptts_pkg::PERIOD_BITS'($urandom());
        else
            per = '1;
        if ($urandom_range(99) < 15)
            tval = 32'hFFFF_FFFF - $urandom_range(3, 0);
        else
            tval = $urandom();
        send_command(kind, ptts_pkg::SLOT_BITS'($urandom_range(ptts_pkg::NUM_SLOTS - 1, 0)),
                     per, tval);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (replies_owed != 0)
            @(posedge clk);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 7;
        recv_idle_pct <= 77;
        send_command(ptts_pkg::KIND_SET, 3'd0, 16'h0000, 32'hFFFF_FFFF);
        send_command(ptts_pkg::KIND_TICK, 3'd0, 16'h0000, 32'h0000_0000);
        send_command(ptts_pkg::KIND_ADD, 3'd0, 16'h0000, 32'h0000_0000);
        send_command(ptts_pkg::KIND_ADD, 3'd7, 16'hFFFF, 32'h0000_0000);
        send_command(ptts_pkg::KIND_ADD, 3'd3, 16'h0001, 32'h0000_0000);
        send_command(ptts_pkg::KIND_ADD, 3'd3, 16'h0002, 32'h0000_0000);
        send_command(ptts_pkg::KIND_SERVICE, 3'd0, 16'h0000, 32'h0000_0000);
        repeat (3)
            send_command(ptts_pkg::KIND_TICK, 3'd0, 16'h0000, 32'h0000_0000);
        repeat (3)
            send_command(ptts_pkg::KIND_SERVICE, 3'd0, 16'h0000, 32'h0000_0000);
        send_command(ptts_pkg::KIND_REMOVE, 3'd7, 16'h0000, 32'h0000_0000);
        send_command(ptts_pkg::KIND_REMOVE, 3'd7, 16'h0000, 32'h0000_0000);
        send_command(ptts_pkg::KIND_ADD, 3'd5, 16'h0000, 32'h0000_0000);
        send_command(ptts_pkg::KIND_TICK, 3'd0, 16'h0000, 32'h0000_0000);
        send_command(ptts_pkg::KIND_REMOVE, 3'd5, 16'h0000, 32'h0000_0000);
        send_command(ptts_pkg::KIND_SERVICE, 3'd0, 16'h0000, 32'h0000_0000);
        send_command(KIND_SPARE_LO, 3'd7, 16'hFFFF, 32'hFFFF_FFFF);
        send_command(KIND_SPARE_HI, 3'd0, 16'h0000, 32'h0000_0000);
        send_command(ptts_pkg::KIND_SET, 3'd5, 16'h5A5A, 32'hA5A5_5A5A);
        send_command(ptts_pkg::KIND_SET, 3'd0, 16'h0000, 32'h0000_0000);
        send_command(ptts_pkg::KIND_ADD, 3'd6, 16'h8000, 32'h0000_0000);
        wait_drained();

        repeat (PHASE_ITEMS)
            send_random();
        wait_drained();

        send_idle_pct = 77;
        recv_idle_pct <= 7;
        repeat (PHASE_ITEMS)
            send_random();
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct <= 0;
        hold_requests <= hold_requests + 1;
        repeat (PHASE_ITEMS)
            send_random();
        wait_drained();

        repeat (4 * ptts_pkg::NUM_SLOTS) @(posedge clk);
        $display("Sent %0d ticks, %0d adds, %0d removes, %0d services, %0d time loads",
                 kind_seen[ptts_pkg::KIND_TICK], kind_seen[ptts_pkg::KIND_ADD],
                 kind_seen[ptts_pkg::KIND_REMOVE], kind_seen[ptts_pkg::KIND_SERVICE],
                 kind_seen[ptts_pkg::KIND_SET]);
        $display("plus spare commands; %0d results compared under three idle mixes and %0s",
                 replies_checked, "one long output hold-off");
        if (fail_count == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

### sim.f
rtl/core/ptts_pkg.sv
rtl/core/ptts_countdown_unit.sv
rtl/core/ptts_slot_bank.sv
rtl/core/periodic_task_tick_scheduler.sv
tb/sv/scheduler_checker.sv
tb/sv/testbench.sv
